### rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Types and constants shared by the timestamp extender modules.
// ----------------------------------------------------------------------------
package pte_pkg;

  localparam int unsigned TickW   = 21;
  localparam int unsigned StatusW = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PhaseW  = 12;
  localparam int unsigned StampW  = 32;

  localparam logic [StampW-1:0] DAY_LENGTH  = 32'h0018_00B0;
  localparam int unsigned       OUT_BIT_POS = 7;

  localparam logic [1:0] MODE_RATE   = 2'd2;
  localparam logic [1:0] MODE_SQUARE = 2'd3;

  typedef logic [TickW-1:0]   tick_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [PhaseW-1:0]  phase_t;
  typedef logic [StampW-1:0]  stamp_t;

endpackage

### rtl/pte_if.sv
// ----------------------------------------------------------------------------
// pte_in_if / pte_out_if
// Valid/ready channels for counter samples and extended timestamps.
// ----------------------------------------------------------------------------
interface pte_in_if
  import pte_pkg::*;
();
  logic    valid;
  logic    ready;
  tick_t   day_tick;
  status_t pit_status;
  count_t  pit_count;

  modport source (output valid, day_tick, pit_status, pit_count, input ready);
  modport sink   (input valid, day_tick, pit_status, pit_count, output ready);
endinterface

interface pte_out_if
  import pte_pkg::*;
();
  logic   valid;
  logic   ready;
  stamp_t timestamp;

  modport source (output valid, timestamp, input ready);
  modport sink   (input valid, timestamp, output ready);
endinterface

### rtl/pit_timestamp_extender.sv
// ----------------------------------------------------------------------------
// pit_timestamp_extender
// Extends a coarse day-tick count with the interval timer phase into a
// wrapping 32-bit timestamp.
//
// Channel    Dir   Payload                               Transfer
// in_chan    in    day_tick, pit_status, pit_count       valid && ready
// out_chan   out   timestamp                             valid && ready
//
// A sample is captured in the input register; the phase, coarse delta and
// running total are then computed from it and written to the result
// register, so one sample can be taken every cycle while the result side
// does not stall. Reset is synchronous and clears the previous sample, the
// running total and both valid flags. A stall on the result side holds the
// result register and then the input register; in_chan.ready falls only
// when both are full.
// ----------------------------------------------------------------------------
module pit_timestamp_extender
  import pte_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pte_in_if.sink    in_chan,
  pte_out_if.source out_chan
);

  logic    in_valid_r, in_valid_nxt;
  tick_t   tick_r;
  status_t status_r;
  count_t  count_r;
  phase_t  phase;
  logic    free;
  logic    load;
  logic    take;

  assign load          = in_valid_r && free;
  assign in_chan.ready = !in_valid_r || free;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    in_valid_nxt = in_valid_r && !free;
    if (take) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tick_r   <= in_chan.day_tick;
      status_r <= in_chan.pit_status;
      count_r  <= in_chan.pit_count;
    end
  end

  pte_phase u_phase (
    .pit_status (status_r),
    .pit_count  (count_r),
    .phase      (phase)
  );

  pte_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .day_tick (tick_r),
    .phase    (phase),
    .free     (free),
    .out_chan (out_chan)
  );

endmodule

### rtl/pte_phase.sv
// ----------------------------------------------------------------------------
// pte_phase
// Derives the 12-bit counter phase from a latched status byte and count.
// ----------------------------------------------------------------------------
module pte_phase
  import pte_pkg::*;
(
  input  status_t pit_status,
  input  count_t  pit_count,
  output phase_t  phase
);

  count_t     elapsed;
  logic [1:0] mode_lo;

  // A count of zero stands for the full range, which yields zero elapsed.
  assign elapsed = count_t'(0) - pit_count;
  assign mode_lo = pit_status[2:1];

  always_comb begin
    case (mode_lo)
      MODE_SQUARE: phase = {~pit_status[OUT_BIT_POS], elapsed[CountW-1:5]};
      MODE_RATE:   phase = elapsed[CountW-1:4];
      default:     phase = '0;
    endcase
  end

endmodule

### rtl/pte_accum.sv
// ----------------------------------------------------------------------------
// pte_accum
// Holds the previous sample, accumulates fine ticks and owns the result register.
// ----------------------------------------------------------------------------
module pte_accum
  import pte_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  tick_t  day_tick,
  input  phase_t phase,
  output logic   free,
  pte_out_if.source out_chan
);

  tick_t  prev_tick_r, prev_tick_nxt;
  phase_t prev_phase_r, prev_phase_nxt;
  logic   started_r, started_nxt;
  logic   owed_r, owed_nxt;
  stamp_t total_r, total_nxt;
  logic   out_valid_r, out_valid_nxt;
  stamp_t stamp_r, stamp_nxt;

  stamp_t coarse_raw;
  stamp_t coarse;
  logic   owe_hit;
  logic   wrap;
  logic   wrap_idle;
  stamp_t add;

  assign free = !out_valid_r || out_chan.ready;

  always_comb begin
    if (day_tick >= prev_tick_r) begin
      coarse_raw = stamp_t'(day_tick - prev_tick_r);
    end else begin
      coarse_raw = DAY_LENGTH - stamp_t'(prev_tick_r) + stamp_t'(day_tick);
    end
    owe_hit   = (coarse_raw != '0) && owed_r;
    coarse    = coarse_raw - stamp_t'(owe_hit);
    wrap      = phase < prev_phase_r;
    wrap_idle = wrap && (coarse == '0);
    add       = {coarse[StampW-PhaseW-1:0], {PhaseW{1'b0}}}
              + stamp_t'(phase) - stamp_t'(prev_phase_r)
              + {{(StampW-PhaseW-1){1'b0}}, wrap_idle, {PhaseW{1'b0}}};
  end

  always_comb begin
    prev_tick_nxt  = prev_tick_r;
    prev_phase_nxt = prev_phase_r;
    started_nxt    = started_r;
    owed_nxt       = owed_r;
    total_nxt      = total_r;
    stamp_nxt      = stamp_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    if (load) begin
      prev_tick_nxt  = day_tick;
      prev_phase_nxt = phase;
      started_nxt    = 1'b1;
      out_valid_nxt  = 1'b1;
      if (started_r) begin
        owed_nxt  = (owed_r && !owe_hit) || wrap_idle;
        total_nxt = total_r + add;
        stamp_nxt = total_r + add;
      end else begin
        stamp_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tick_r  <= '0;
      prev_phase_r <= '0;
      started_r    <= 1'b0;
      owed_r       <= 1'b0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      prev_tick_r  <= prev_tick_nxt;
      prev_phase_r <= prev_phase_nxt;
      started_r    <= started_nxt;
      owed_r       <= owed_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.timestamp = stamp_r;

endmodule
